[rtl/ffst_pkg.sv]
package ffst_pkg;

  localparam logic [1:0] UNBURNT    = 2'd0;
  localparam logic [1:0] SMOLDERING = 2'd1;
  localparam logic [1:0] BURNING    = 2'd2;
  localparam logic [1:0] BURNT      = 2'd3;

  localparam int TICK_W  = 12;
  localparam int BURNT_W = 11;
  localparam int FRAC_W  = 16;
  localparam int SEED_W  = 32;
  localparam int THR_W   = 17;
  localparam int POS_W   = 5;
  localparam int SIZE_W  = 6;

  // Neighbor visit order
  typedef enum logic [1:0] {
    DIR_N = 2'd0,
    DIR_S = 2'd1,
    DIR_W = 2'd2,
    DIR_E = 2'd3
  } dir_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_LIGHT,
    ST_AGE_RD,
    ST_AGE_WR,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_NB_RD,
    ST_NB_WR,
    ST_COUNT,
    ST_DIV,
    ST_DONE
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;        // latch input beat, reset counters
    logic clr_start;   // position sweep at origin
    logic clr_step;    // write unburnt, advance sweep
    logic light;       // write smoldering at start cell
    logic rd_pos;      // read memory at sweep position
    logic age_wr;      // write aged cell, track activity, advance
    logic nb_rd;       // draw and read current neighbor
    logic nb_wr;       // apply spread, move to next neighbor
    logic nb_first;    // select first neighbor of current cell
    logic scan_next;   // advance sweep position
    logic tick_inc;    // count a tick
    logic cnt_step;    // count burnt at read data, advance
    logic div_start;
    logic div_step;
  } ffst_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic sweep_last;  // sweep position is last cell
    logic active;      // a cell remained active in the last aging pass
    logic is_burning;  // read data is burning
    logic nb_valid;    // a neighbor remains for the current cell
    logic div_done;
  } ffst_stat_t;

  // One xorshift step
  function automatic logic [31:0] xs_next(input logic [31:0] x);
    logic [31:0] y;
    y = x ^ (x << 13);
    y = y ^ (y >> 17);
    y = y ^ (y << 5);
    return y;
  endfunction

endpackage

[rtl/ffst_ctrl.sv]
module ffst_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  ffst_pkg::ffst_stat_t stat,
  output ffst_pkg::ffst_cmd_t  cmd
);
  import ffst_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:     if (in_valid) state_next = ST_CLEAR;
      ST_CLEAR:    if (stat.sweep_last) state_next = ST_LIGHT;
      ST_LIGHT:    state_next = ST_AGE_RD;
      ST_AGE_RD:   state_next = ST_AGE_WR;
      ST_AGE_WR:   if (stat.sweep_last) state_next = ST_SCAN_RD;
                   else state_next = ST_AGE_RD;
      ST_SCAN_RD:  if (!stat.active) state_next = ST_COUNT;
                   else state_next = ST_SCAN_CHK;
      ST_SCAN_CHK: begin
        if (stat.is_burning) state_next = ST_NB_RD;
        else if (stat.sweep_last) state_next = ST_AGE_RD;
        else state_next = ST_SCAN_CHK;
      end
      ST_NB_RD:    state_next = ST_NB_WR;
      ST_NB_WR: begin
        if (stat.nb_valid) state_next = ST_NB_RD;
        else if (stat.sweep_last) state_next = ST_AGE_RD;
        else state_next = ST_SCAN_CHK;
      end
      ST_COUNT:    if (stat.sweep_last) state_next = ST_DIV;
      ST_DIV:      if (stat.div_done) state_next = ST_DONE;
      ST_DONE:     if (!out_stall) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_stall      = 1'b0;
        cmd.load      = in_valid;
        cmd.clr_start = in_valid;
      end
      ST_CLEAR: begin
        cmd.clr_step  = 1'b1;
      end
      ST_LIGHT: begin
        cmd.light     = 1'b1;
        cmd.clr_start = 1'b1;
      end
      ST_AGE_RD:  cmd.rd_pos = 1'b1;
      ST_AGE_WR: begin
        cmd.age_wr    = 1'b1;
        cmd.clr_start = stat.sweep_last;
      end
      ST_SCAN_RD: begin
        // memory read of cell 0 issued here; with no activity start count
        cmd.rd_pos    = 1'b1;
        cmd.tick_inc  = stat.active;
      end
      ST_SCAN_CHK: begin
        if (stat.is_burning) begin
          cmd.nb_first = 1'b1;
        end else if (stat.sweep_last) begin
          cmd.clr_start = 1'b1;
        end else begin
          cmd.scan_next = 1'b1;
          cmd.rd_pos    = 1'b1;
        end
      end
      ST_NB_RD:   cmd.nb_rd = 1'b1;
      ST_NB_WR: begin
        cmd.nb_wr = 1'b1;
        if (!stat.nb_valid) begin
          if (stat.sweep_last) begin
            cmd.clr_start = 1'b1;
          end else begin
            cmd.scan_next = 1'b1;
            cmd.rd_pos    = 1'b1;
          end
        end
      end
      ST_COUNT: begin
        cmd.cnt_step  = 1'b1;
        cmd.rd_pos    = 1'b1;
        cmd.div_start = stat.sweep_last;
      end
      ST_DIV:     cmd.div_step = 1'b1;
      ST_DONE:    out_valid = 1'b1;
      default: ;
    endcase
  end

endmodule

[rtl/ffst_datapath.sv]
module ffst_datapath #(
  parameter int MAX_GRID = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [ffst_pkg::SIZE_W-1:0] cfg_data,
  input  logic [ffst_pkg::SEED_W-1:0] trial_seed,
  input  logic [ffst_pkg::THR_W-1:0]  spread_threshold,
  input  logic [ffst_pkg::POS_W-1:0]  start_row,
  input  logic [ffst_pkg::POS_W-1:0]  start_col,
  input  ffst_pkg::ffst_cmd_t         cmd,
  output ffst_pkg::ffst_stat_t        stat,
  output logic [ffst_pkg::TICK_W-1:0] tick_count,
  output logic [ffst_pkg::BURNT_W-1:0] burnt_cells,
  output logic [ffst_pkg::FRAC_W-1:0] burnt_fraction
);
  import ffst_pkg::*;

  localparam int CW    = $clog2(MAX_GRID);
  localparam int AW    = 2 * CW;
  localparam int NW    = CW + 1;          // holds MAX_GRID
  localparam int BCW   = 2 * CW + 1;      // holds MAX_GRID^2
  localparam int DENW  = 2 * CW + 1;
  localparam int DIVQ  = FRAC_W + BCW;    // quotient bits computed
  localparam int DSW   = $clog2(DIVQ + 1);

  // Configuration register
  logic [SIZE_W-1:0] grid_size;
  always_ff @(posedge clk) begin
    if (rst)         grid_size <= SIZE_W'(20);
    else if (cfg_we) grid_size <= cfg_data;
  end

  logic [NW-1:0] n_eff;
  always_comb begin
    if (grid_size < SIZE_W'(2))
      n_eff = NW'(2);
    else if (32'(grid_size) > 32'(MAX_GRID))
      n_eff = NW'(MAX_GRID);
    else
      n_eff = NW'(grid_size);
  end

  // Per-trial latched values
  logic [NW-1:0]   n;
  logic [CW-1:0]   nm1;
  logic [THR_W-1:0] thr;
  logic [CW-1:0]   sr, sc;
  logic [31:0]     rnd;

  // Start position compare at full width so any grid size clamps right
  logic [31:0] sr_full, sc_full, n_last;
  assign sr_full = 32'(start_row);
  assign sc_full = 32'(start_col);
  assign n_last  = 32'(n_eff) - 32'd1;

  // Sweep position
  logic [CW-1:0] pr, pc;
  logic          pos_last;
  assign pos_last = (pr == nm1) && (pc == nm1);

  // Neighbor selection
  logic [1:0]    dir;
  logic [3:0]    nb_mask;
  logic [CW-1:0] nr, nc;
  logic          active, seen_active;

  // Grid memory, row stride of 2^CW
  logic [1:0] grid [1 << AW];
  logic [1:0] rd_data;
  logic       mem_we;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [1:0] wr_val;

  // Counters and divider
  logic [TICK_W-1:0] ticks;
  logic [BCW-1:0]    burnt;
  logic [DIVQ-1:0]   quo;
  logic [DENW:0]     rem;
  logic [DENW-1:0]   den;
  logic [DIVQ-1:0]   dividend;
  logic [DSW-1:0]    div_cnt;
  logic              div_busy;

  logic [31:0] draw_state;
  assign draw_state = xs_next(rnd);

  // Neighbor presence and address for a direction
  function automatic logic [3:0] nb_present(input logic [CW-1:0] r, input logic [CW-1:0] c,
                                            input logic [CW-1:0] last);
    logic [3:0] m;
    m[DIR_N] = (r != '0);
    m[DIR_S] = (r != last);
    m[DIR_W] = (c != '0);
    m[DIR_E] = (c != last);
    return m;
  endfunction

  always_comb begin
    nr = pr;
    nc = pc;
    unique case (dir_t'(dir))
      DIR_N: nr = pr - CW'(1);
      DIR_S: nr = pr + CW'(1);
      DIR_W: nc = pc - CW'(1);
      DIR_E: nc = pc + CW'(1);
      default: ;
    endcase
  end

  // Next present direction above the current one
  logic [3:0] rest_mask;
  logic [1:0] next_dir;
  logic       has_next;
  always_comb begin
    rest_mask = nb_mask & ~((4'b0010 << dir) - 4'b0001);
    has_next  = (rest_mask != '0);
    next_dir  = 2'd0;
    for (int i = 3; i >= 0; i--)
      if (rest_mask[i]) next_dir = 2'(i);
  end

  // First present direction of the current cell
  logic [3:0] first_mask;
  logic [1:0] first_dir;
  always_comb begin
    first_mask = nb_present(pr, pc, nm1);
    first_dir  = 2'd0;
    for (int i = 3; i >= 0; i--)
      if (first_mask[i]) first_dir = 2'(i);
  end

  // Trial control registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n   <= n_eff;
      nm1 <= CW'(n_eff - NW'(1));
      thr <= spread_threshold;
      sr  <= (sr_full > n_last) ? CW'(n_last) : CW'(sr_full);
      sc  <= (sc_full > n_last) ? CW'(n_last) : CW'(sc_full);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rnd <= 32'd1;
    end else if (cmd.load) begin
      rnd <= (trial_seed == '0) ? 32'd1 : trial_seed;
    end else if (cmd.nb_rd) begin
      rnd <= draw_state;
    end
  end

  // Sweep position walk
  always_ff @(posedge clk) begin
    if (cmd.clr_start) begin
      pr <= '0;
      pc <= '0;
    end else if (cmd.clr_step || cmd.age_wr || cmd.scan_next || cmd.cnt_step) begin
      if (pc == nm1) begin
        pc <= '0;
        pr <= pr + CW'(1);
      end else begin
        pc <= pc + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.nb_first) begin
      nb_mask <= first_mask;
      dir     <= first_dir;
    end else if (cmd.nb_wr) begin
      dir <= next_dir;
    end
  end

  // Spread decision registered with draw
  logic hit;
  always_ff @(posedge clk) begin
    if (cmd.nb_rd) hit <= ({1'b0, draw_state[31:16]} < thr);
  end

  // Activity tracking across an aging pass
  always_ff @(posedge clk) begin
    if (rst) begin
      seen_active <= 1'b0;
      active      <= 1'b0;
    end else if (cmd.light) begin
      seen_active <= 1'b0;
    end else if (cmd.age_wr) begin
      if (pos_last) begin
        active      <= seen_active || rd_data == SMOLDERING || rd_data == BURNING;
        seen_active <= 1'b0;
      end else if (rd_data == SMOLDERING || rd_data == BURNING) begin
        seen_active <= 1'b1;
      end
    end
  end

  // Memory port selection
  always_comb begin
    mem_we  = 1'b0;
    wr_addr = {pr, pc};
    wr_val  = UNBURNT;
    rd_addr = {pr, pc};
    if (cmd.clr_step) begin
      mem_we = 1'b1;
    end else if (cmd.light) begin
      mem_we  = 1'b1;
      wr_addr = {sr, sc};
      wr_val  = SMOLDERING;
    end else if (cmd.age_wr) begin
      mem_we = 1'b1;
      wr_val = (rd_data == BURNING) ? BURNT :
               (rd_data == SMOLDERING) ? BURNING : rd_data;
    end else if (cmd.nb_wr) begin
      mem_we  = hit && (rd_data == UNBURNT);
      wr_addr = {nr, nc};
      wr_val  = SMOLDERING;
    end
    if (cmd.nb_rd) rd_addr = {nr, nc};
    else if (cmd.scan_next || cmd.cnt_step || cmd.age_wr) begin
      // read ahead at the following cell
      if (pc == nm1) rd_addr = {pr + CW'(1), CW'(0)};
      else           rd_addr = {pr, pc + CW'(1)};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) grid[wr_addr] <= wr_val;
  end

  always_ff @(posedge clk) begin
    rd_data <= grid[rd_addr];
  end

  // Tick and burnt counters
  always_ff @(posedge clk) begin
    if (rst) begin
      ticks <= '0;
    end else if (cmd.load) begin
      ticks <= '0;
    end else if (cmd.tick_inc && ticks != '1) begin
      ticks <= ticks + TICK_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) burnt <= '0;
    else if (cmd.cnt_step && rd_data == BURNT) burnt <= burnt + BCW'(1);
  end

  // Restoring divider, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
      div_cnt  <= '0;
    end else if (cmd.div_start) begin
      div_busy <= 1'b1;
      div_cnt  <= DSW'(DIVQ);
      rem      <= '0;
      den      <= DENW'(32'(n) * 32'(n) - 32'd1);
      dividend <= (burnt == '0 && rd_data != BURNT) ? '0 :
                  (DIVQ'((rd_data == BURNT) ? burnt : burnt - BCW'(1)) << FRAC_W);
    end else if (cmd.div_step && div_busy) begin
      if (div_cnt == DSW'(1)) div_busy <= 1'b0;
      div_cnt  <= div_cnt - DSW'(1);
      dividend <= {dividend[DIVQ-2:0], 1'b0};
      if ({rem[DENW-1:0], dividend[DIVQ-1]} >= {1'b0, den}) begin
        rem <= {rem[DENW-1:0], dividend[DIVQ-1]} - {1'b0, den};
        quo <= {quo[DIVQ-2:0], 1'b1};
      end else begin
        rem <= {rem[DENW-1:0], dividend[DIVQ-1]};
        quo <= {quo[DIVQ-2:0], 1'b0};
      end
    end
  end

  // Last count includes the final read, folded in at div_start
  logic [BCW-1:0] burnt_final;
  always_ff @(posedge clk) begin
    if (cmd.div_start) burnt_final <= burnt + BCW'(rd_data == BURNT);
  end

  assign tick_count     = ticks;
  assign burnt_cells    = (32'(burnt_final) > 2047) ? BURNT_W'(2047) : BURNT_W'(burnt_final);
  assign burnt_fraction = (quo > DIVQ'(65535)) ? FRAC_W'(65535) : quo[FRAC_W-1:0];

  assign stat.sweep_last = pos_last;
  assign stat.active     = active;
  assign stat.is_burning = (rd_data == BURNING);
  assign stat.nb_valid   = has_next;
  assign stat.div_done   = div_busy && div_cnt == DSW'(1);

endmodule

[rtl/forest_fire_spread_trial.sv]
// Forest fire spread trial. Each accepted input beat runs one full Monte Carlo
// fire on an N x N grid (N from grid_size, held to 2..MAX_GRID) and returns one
// result beat. A trial clears the grid, then per tick runs an aging pass, a scan
// and a neighbor draw for every neighbor of each burning cell, then one more
// aging pass that finds the fire out, a count pass and the fraction divider; the
// grid memory, with one read port and one write port, sets the pace. One trial
// is in flight at a time; the user must write grid_size only while idle, as the
// block itself does not enforce it.
module forest_fire_spread_trial #(
  parameter int MAX_GRID = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [5:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] trial_seed,
  input  logic [16:0] spread_threshold,
  input  logic [4:0]  start_row,
  input  logic [4:0]  start_col,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [11:0] tick_count,
  output logic [10:0] burnt_cells,
  output logic [15:0] burnt_fraction
);
  import ffst_pkg::*;

  ffst_cmd_t  cmd;
  ffst_stat_t stat;

  ffst_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  ffst_datapath #(.MAX_GRID(MAX_GRID)) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_data         (cfg_data),
    .trial_seed       (trial_seed),
    .spread_threshold (spread_threshold),
    .start_row        (start_row),
    .start_col        (start_col),
    .cmd              (cmd),
    .stat             (stat),
    .tick_count       (tick_count),
    .burnt_cells      (burnt_cells),
    .burnt_fraction   (burnt_fraction)
  );

endmodule

[rtl/ffst_checker.sv]
module ffst_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [10:0] burnt_cells,
  input logic [11:0] tick_count
);

  // No new trial taken while a result beat is pending
  a_no_accept_while_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input taken while result pending");

  // A result never shows in the cycle right after an input beat
  a_not_immediate: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> !out_valid) else $error("result too early");

  // Every result has the start cell burnt and at least one tick
  a_min_result: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (burnt_cells != 11'd0 && tick_count != 12'd0))
    else $error("empty trial result");

  // Held result stays valid with burnt_cells stable under stall
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(burnt_cells)))
    else $error("result dropped under stall");

endmodule

bind forest_fire_spread_trial ffst_checker u_ffst_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .burnt_cells (burnt_cells),
  .tick_count  (tick_count)
);

[tb/tb_top.sv]
module tb_top;
  import ffst_pkg::*;

  localparam int GRID_CAP   = 32;
  localparam int CYCLE_CAP  = 40000000;
  localparam int DRAIN_WAIT = 64;

  typedef struct packed {
    logic [TICK_W-1:0]  ticks;
    logic [BURNT_W-1:0] burnt;
    logic [FRAC_W-1:0]  frac;
  } fire_result_t;

  // Predicts each trial from the accepted input beat and checks result beats in order
  class fire_scoreboard;
    logic [1:0]   grid [GRID_CAP][GRID_CAP];
    logic [31:0]  rng;
    logic [5:0]   size_reg;
    fire_result_t pending [$];
    int           mismatches;
    int           checked;

    function new();
      size_reg   = 6'd20;
      mismatches = 0;
      checked    = 0;
    endfunction

    function logic [15:0] draw();
      rng = rng ^ (rng << 13);
      rng = rng ^ (rng >> 17);
      rng = rng ^ (rng << 5);
      return rng[31:16];
    endfunction

    function void spread_to(int r, int c, logic [16:0] thr);
      logic hit;
      hit = {1'b0, draw()} < thr;
      if (hit && grid[r][c] == UNBURNT) grid[r][c] = SMOLDERING;
    endfunction

    // Run one whole fire and queue its result
    function void note_trial(logic [31:0] seed, logic [16:0] thr,
                             logic [4:0] row, logic [4:0] col);
      int n, sr, sc, ticks, burnt;
      bit live;
      longint q;
      fire_result_t res;
      n = size_reg;
      if (n < 2) n = 2;
      if (n > GRID_CAP) n = GRID_CAP;
      sr = (row > n - 1) ? n - 1 : row;
      sc = (col > n - 1) ? n - 1 : col;
      rng = (seed == 0) ? 32'd1 : seed;
      for (int r = 0; r < n; r++)
        for (int c = 0; c < n; c++) grid[r][c] = UNBURNT;
      grid[sr][sc] = SMOLDERING;
      ticks = 0;
      live = 1;
      while (live) begin
        // age pass
        for (int r = 0; r < n; r++)
          for (int c = 0; c < n; c++) begin
            if (grid[r][c] == BURNING) grid[r][c] = BURNT;
            else if (grid[r][c] == SMOLDERING) grid[r][c] = BURNING;
          end
        // spread pass, neighbors N S W E
        for (int r = 0; r < n; r++)
          for (int c = 0; c < n; c++) begin
            if (grid[r][c] != BURNING) continue;
            if (r != 0) spread_to(r - 1, c, thr);
            if (r != n - 1) spread_to(r + 1, c, thr);
            if (c != 0) spread_to(r, c - 1, thr);
            if (c != n - 1) spread_to(r, c + 1, thr);
          end
        if (ticks < 4095) ticks++;
        live = 0;
        for (int r = 0; r < n; r++)
          for (int c = 0; c < n; c++)
            if (grid[r][c] == SMOLDERING || grid[r][c] == BURNING) live = 1;
      end
      burnt = 0;
      for (int r = 0; r < n; r++)
        for (int c = 0; c < n; c++)
          if (grid[r][c] == BURNT) burnt++;
      q = 0;
      if (burnt > 0) q = (longint'(burnt - 1) << 16) / (longint'(n) * n - 1);
      res.ticks = TICK_W'(ticks);
      res.burnt = (burnt > 2047) ? BURNT_W'(2047) : BURNT_W'(burnt);
      res.frac  = (q > 65535) ? 16'hFFFF : q[15:0];
      pending.push_back(res);
    endfunction

    function void check_result(fire_result_t got);
      fire_result_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected result beat %p", got);
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result %0d ticks %0d/%0d burnt %0d/%0d frac %0d/%0d (exp/act)",
                   checked, want.ticks, got.ticks, want.burnt, got.burnt,
                   want.frac, got.frac);
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_we = 0;
  logic [5:0]  cfg_data = '0;
  logic        in_valid = 0;
  logic        in_stall;
  logic [31:0] trial_seed = '0;
  logic [16:0] spread_threshold = '0;
  logic [4:0]  start_row = '0;
  logic [4:0]  start_col = '0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [11:0] tick_count;
  logic [10:0] burnt_cells;
  logic [15:0] burnt_fraction;

  fire_scoreboard fires = new();
  int cycles = 0;
  int burst_left = 0;
  int trials_sent = 0;
  int sizes_used = 0;

  forest_fire_spread_trial DUT (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .trial_seed(trial_seed), .spread_threshold(spread_threshold),
    .start_row(start_row), .start_col(start_col),
    .out_valid(out_valid), .out_stall(out_stall),
    .tick_count(tick_count), .burnt_cells(burnt_cells),
    .burnt_fraction(burnt_fraction)
  );

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Receiver stall pattern: phases of none, light and heavy back-pressure
  int stall_mode = 0;
  int stall_left = 0;
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(20, 200);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0: out_stall = 1'b0;
      1: out_stall = ($urandom_range(0, 3) == 0);
      default: out_stall = ($urandom_range(0, 3) != 0);
    endcase
  end

  // Result monitor
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      fires.check_result({tick_count, burnt_cells, burnt_fraction});
  end

  // One input beat; bursts keep valid high, gaps drop it
  task automatic send_trial(logic [31:0] seed, logic [16:0] thr,
                            logic [4:0] row, logic [4:0] col);
    @(negedge clk);
    in_valid = 1;
    trial_seed = seed;
    spread_threshold = thr;
    start_row = row;
    start_col = col;
    do @(posedge clk); while (in_stall);
    fires.note_trial(seed, thr, row, col);
    trials_sent++;
    if (burst_left == 0) begin
      burst_left = $urandom_range(0, 4);
      @(negedge clk);
      in_valid = 0;
      repeat ($urandom_range(0, 12)) @(negedge clk);
    end else begin
      burst_left--;
    end
  endtask

  // Wait for idle, then write the grid size
  task automatic write_size(logic [5:0] val);
    @(negedge clk);
    in_valid = 0;
    while (fires.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    @(negedge clk);
    cfg_we = 1;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 0;
    fires.size_reg = val;
    sizes_used++;
  endtask

  task automatic random_trials(int count);
    logic [16:0] thr;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 3))
        0: thr = 17'($urandom_range(0, 131071));
        1: thr = 17'($urandom_range(65536, 131071));
        default: thr = 17'($urandom_range(20000, 65535));
      endcase
      send_trial($urandom, thr, 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)));
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Reset size, a full burn and a dead start
    send_trial(32'd0, 17'd65536, 5'd31, 5'd31);
    send_trial(32'hFFFF_FFFF, 17'd0, 5'd0, 5'd0);

    // Below-range and above-range sizes
    write_size(6'd0);
    send_trial(32'h1234_5678, 17'h1FFFF, 5'd0, 5'd31);
    send_trial(32'd0, 17'd0, 5'd31, 5'd0);
    write_size(6'd1);
    send_trial(32'hDEAD_BEEF, 17'd65535, 5'd1, 5'd1);
    write_size(6'd63);
    send_trial(32'h8000_0001, 17'd65536, 5'd31, 5'd31);
    send_trial(32'h0F0F_0F0F, 17'd1, 5'd0, 5'd0);

    // Small grid extremes
    write_size(6'd4);
    send_trial(32'd0, 17'd65535, 5'd0, 5'd0);
    send_trial(32'hFFFF_FFFF, 17'd65536, 5'd3, 5'd3);
    send_trial(32'hAAAA_AAAA, 17'd32768, 5'd31, 5'd2);
    send_trial(32'h5555_5555, 17'd1, 5'd2, 5'd31);
    send_trial(32'd1, 17'h1FFFF, 5'd16, 5'd8);
    send_trial(32'h7FFF_FFFF, 17'd0, 5'd1, 5'd2);

    // Random part: mostly small grids, a few large ones
    write_size(6'd2);  random_trials(12);
    write_size(6'd3);  random_trials(14);
    write_size(6'd5);  random_trials(14);
    write_size(6'd7);  random_trials(12);
    write_size(6'd6);  random_trials(12);
    write_size(6'd11); random_trials(8);
    write_size(6'd8);  random_trials(10);
    write_size(6'd16); random_trials(4);
    write_size(6'd32); random_trials(2);
    write_size(6'd3);  random_trials(10);

    @(negedge clk);
    in_valid = 0;
    while (fires.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Ran %0d fire trials over %0d grid size writes; %0d results checked.",
             trials_sent, sizes_used, fires.checked);
    $display("Mismatches: %0d", fires.mismatches);
    if (fires.mismatches == 0 && fires.pending.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

[filelist.f]
rtl/ffst_pkg.sv
rtl/ffst_ctrl.sv
rtl/ffst_datapath.sv
rtl/forest_fire_spread_trial.sv
rtl/ffst_checker.sv
tb/tb_top.sv
